### hw/rtl/nqsc_pkg.sv
package nqsc_pkg;

  localparam int NQ_MAX_SIZE = 16;

  localparam int BOARD_W    = 5;
  localparam int SHOW_W     = 2;
  localparam int QROW_W     = 4;
  localparam int ROWS_OUT_W = 64;
  localparam int SOL_W      = 24;
  localparam int TEST_W     = 40;
  localparam int CFG_W      = 5;
  localparam int CFG_IDX_W  = 2;

  localparam logic [BOARD_W-1:0] BOARD_RST = BOARD_W'(8);
  localparam logic [SHOW_W-1:0]  SHOW_RST  = SHOW_W'(3);

  localparam logic [CFG_IDX_W-1:0] REG_BOARD_SIZE = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_SHOWN_SOLS = CFG_IDX_W'(1);

  localparam logic KIND_SOLUTION = 1'b0;
  localparam logic KIND_SUMMARY  = 1'b1;

  localparam logic [SOL_W-1:0]  SOL_MAX  = '1;
  localparam logic [TEST_W-1:0] TEST_MAX = '1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SEARCH,
    S_SUMMARY
  } nq_state_t;

  // control from sequencer to the occupancy unit
  typedef struct packed {
    logic clear;
    logic flip;
  } nq_mask_ctl_t;

endpackage

### hw/rtl/nqsc_mask_unit.sv
module nqsc_mask_unit
  import nqsc_pkg::*;
#(
  parameter int MAX_SIZE = NQ_MAX_SIZE
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  nq_mask_ctl_t                ctl,
  input  logic [$clog2(MAX_SIZE)-1:0] col,
  input  logic [$clog2(MAX_SIZE)-1:0] row,
  output logic                        safe
);

  localparam int IDX_W   = $clog2(MAX_SIZE);
  localparam int DIAG_W  = 2 * MAX_SIZE - 1;
  localparam int DIAG_IW = $clog2(DIAG_W);

  logic [MAX_SIZE-1:0] rows_r, rows_nxt;
  logic [DIAG_W-1:0]   rise_r, rise_nxt;
  logic [DIAG_W-1:0]   fall_r, fall_nxt;
  logic [DIAG_IW-1:0]  rise_idx;
  logic [DIAG_IW-1:0]  fall_idx;
  logic [IDX_W-1:0]    row_idx;

  assign row_idx  = row;
  assign rise_idx = DIAG_IW'(row) + DIAG_IW'(col);
  assign fall_idx = DIAG_IW'(row) + DIAG_IW'(MAX_SIZE - 1) - DIAG_IW'(col);

  assign safe = !rows_r[row_idx] && !rise_r[rise_idx] && !fall_r[fall_idx];

  always_comb begin
    rows_nxt = rows_r;
    rise_nxt = rise_r;
    fall_nxt = fall_r;
    if (ctl.clear) begin
      rows_nxt = '0;
      rise_nxt = '0;
      fall_nxt = '0;
    end else if (ctl.flip) begin
      rows_nxt = rows_r ^ (MAX_SIZE'(1) << row_idx);
      rise_nxt = rise_r ^ (DIAG_W'(1) << rise_idx);
      fall_nxt = fall_r ^ (DIAG_W'(1) << fall_idx);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r <= '0;
      rise_r <= '0;
      fall_r <= '0;
    end else begin
      rows_r <= rows_nxt;
      rise_r <= rise_nxt;
      fall_r <= fall_nxt;
    end
  end

endmodule

### hw/rtl/n_queens_solution_counter.sv
// The search takes a step for each safety test and for each backtrack, plus a start
// and a summary hand-over.
// Throughput: one search at a time; the input is stalled until the summary
// beat has been loaded. A waiting placement record holds the search.
// Reset (rst_n, synchronous): board_size 8, shown_solutions 3, idle, counts zero.
module n_queens_solution_counter
  import nqsc_pkg::*;
#(
  parameter int MAX_SIZE = NQ_MAX_SIZE
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_W-1:0]      cfg_data,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  in_start_req,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  out_record_kind,
  output logic [SHOW_W-1:0]     out_solution_number,
  output logic [ROWS_OUT_W-1:0] out_queen_rows,
  output logic [SOL_W-1:0]      out_solution_total,
  output logic [TEST_W-1:0]     out_tests_total,
  output logic                  out_last
);

  localparam int ROW_W = $clog2(MAX_SIZE + 1);
  localparam int IDX_W = $clog2(MAX_SIZE);

  nq_state_t state_r, state_nxt;

  logic [BOARD_W-1:0] board_size_r;
  logic [SHOW_W-1:0]  shown_r;

  logic [ROW_W-1:0]  n_r, n_nxt;
  logic [SHOW_W-1:0] show_r;
  logic [ROW_W-1:0]  col_r, col_nxt;
  logic [ROW_W-1:0]  row_r, row_nxt;
  logic [MAX_SIZE-1:0][QROW_W-1:0] cols_r;
  logic [SOL_W-1:0]  sol_r, sol_inc;
  logic [TEST_W-1:0] test_r, test_inc;

  logic out_valid_r;
  logic out_kind_r, out_last_r;
  logic [SHOW_W-1:0]     out_num_r;
  logic [ROWS_OUT_W-1:0] out_rows_r;
  logic [SOL_W-1:0]      out_sol_r;
  logic [TEST_W-1:0]     out_test_r;

  logic start, out_free;
  logic at_end, exhausted, is_back, want_emit, hold, step_en;
  logic finish, pop, test, place, emit_sol, emit_sum;
  logic [IDX_W-1:0]  pop_col;
  logic [QROW_W-1:0] stored_row;
  logic [IDX_W-1:0]  unit_col, unit_row;
  logic              safe;
  nq_mask_ctl_t      mask_ctl;

  assign in_stall = (state_r != S_IDLE);
  assign start    = in_valid && !in_stall && in_start_req;
  assign out_free = !out_valid_r || !out_stall;

  assign n_nxt = (board_size_r > BOARD_W'(MAX_SIZE)) ? ROW_W'(MAX_SIZE)
                                                      : ROW_W'(board_size_r);

  // step decode
  always_comb begin
    at_end     = (col_r >= n_r);
    exhausted  = (row_r >= n_r);
    is_back    = at_end || exhausted;
    sol_inc    = (sol_r == SOL_MAX) ? sol_r : sol_r + SOL_W'(1);
    test_inc   = (test_r == TEST_MAX) ? test_r : test_r + TEST_W'(1);
    want_emit  = at_end && (sol_inc <= SOL_W'(show_r));
    hold       = is_back && want_emit && !out_free;
    step_en    = (state_r == S_SEARCH) && !hold;
    finish     = step_en && is_back && (col_r == '0);
    pop        = step_en && is_back && (col_r != '0);
    test       = step_en && !is_back;
    pop_col    = IDX_W'(col_r - ROW_W'(1));
    stored_row = cols_r[pop_col];
    unit_col   = is_back ? pop_col : IDX_W'(col_r);
    unit_row   = is_back ? IDX_W'(stored_row) : IDX_W'(row_r);
    place      = test && safe;
    emit_sol   = step_en && at_end && want_emit;
    emit_sum   = (state_r == S_SUMMARY) && out_free;
    mask_ctl.clear = start;
    mask_ctl.flip  = pop || place;
  end

  nqsc_mask_unit #(
    .MAX_SIZE (MAX_SIZE)
  ) u_mask (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (mask_ctl),
    .col   (unit_col),
    .row   (unit_row),
    .safe  (safe)
  );

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (start) begin
      col_nxt = '0;
      row_nxt = '0;
    end else if (pop) begin
      col_nxt = col_r - ROW_W'(1);
      row_nxt = ROW_W'(stored_row) + ROW_W'(1);
    end else if (place) begin
      col_nxt = col_r + ROW_W'(1);
      row_nxt = '0;
    end else if (test) begin
      row_nxt = row_r + ROW_W'(1);
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:    if (start) state_nxt = S_SEARCH;
      S_SEARCH:  if (finish) state_nxt = S_SUMMARY;
      S_SUMMARY: if (out_free) state_nxt = S_IDLE;
      default:   state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      board_size_r <= BOARD_RST;
      shown_r      <= SHOW_RST;
      col_r        <= '0;
      row_r        <= '0;
      sol_r        <= '0;
      test_r       <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      col_r   <= col_nxt;
      row_r   <= row_nxt;
      if (cfg_wr_en) begin
        unique case (cfg_index)
          REG_BOARD_SIZE: board_size_r <= BOARD_W'(cfg_data);
          REG_SHOWN_SOLS: shown_r      <= SHOW_W'(cfg_data);
          default: ;
        endcase
      end
      if (start) begin
        sol_r  <= '0;
        test_r <= '0;
      end else begin
        if (step_en && at_end) sol_r <= sol_inc;
        if (test) test_r <= test_inc;
      end
      if (emit_sol || emit_sum) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // placement store and output beat payload
  always_ff @(posedge clk) begin
    if (start) begin
      n_r    <= n_nxt;
      show_r <= shown_r;
      cols_r <= '0;
    end else if (pop) begin
      cols_r[pop_col] <= '0;
    end else if (place) begin
      cols_r[IDX_W'(col_r)] <= QROW_W'(row_r);
    end
    if (emit_sol) begin
      out_kind_r <= KIND_SOLUTION;
      out_num_r  <= SHOW_W'(sol_inc);
      out_rows_r <= ROWS_OUT_W'(cols_r);
      out_sol_r  <= '0;
      out_test_r <= '0;
      out_last_r <= 1'b0;
    end else if (emit_sum) begin
      out_kind_r <= KIND_SUMMARY;
      out_num_r  <= '0;
      out_rows_r <= '0;
      out_sol_r  <= sol_r;
      out_test_r <= test_r;
      out_last_r <= 1'b1;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_record_kind     = out_kind_r;
  assign out_solution_number = out_num_r;
  assign out_queen_rows      = out_rows_r;
  assign out_solution_total  = out_sol_r;
  assign out_tests_total     = out_test_r;
  assign out_last            = out_last_r;

  a_start_enters_search: assert property (@(posedge clk) disable iff (!rst_n)
    start |=> (state_r == S_SEARCH))
    else $error("start did not enter search");

  a_idle_column_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE || state_r == S_SUMMARY) |-> (col_r == '0))
    else $error("column stack not empty outside search");

  a_column_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SEARCH) |-> (col_r <= n_r))
    else $error("column beyond board size");

  a_solution_ordinal: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_last) |-> (out_solution_number != '0 &&
                                  out_record_kind == KIND_SOLUTION))
    else $error("placement beat with bad ordinal");

endmodule

### bench/n_queens_solution_counter_tb.sv
module n_queens_solution_counter_tb
  import nqsc_pkg::*;
;

  localparam int RANDOM_STARTS = 105;
  localparam int SETTLE_CYCLES = 32;
  localparam int DRAIN_LIMIT   = 2000000;
  localparam int REPORT_LIMIT  = 10;

  typedef struct {
    logic                  kind;
    logic [SHOW_W-1:0]     number;
    logic [ROWS_OUT_W-1:0] rows;
    logic [SOL_W-1:0]      sol_total;
    logic [TEST_W-1:0]     test_total;
    logic                  last;
  } nq_record_t;

  class nq_scoreboard;
    logic [BOARD_W-1:0]      board_cfg = BOARD_RST;
    logic [SHOW_W-1:0]       show_cfg  = SHOW_RST;
    logic [QROW_W-1:0]       col_rows [NQ_MAX_SIZE];
    logic [NQ_MAX_SIZE-1:0]  rows_taken;
    logic [2*NQ_MAX_SIZE-2:0] rise_taken;
    logic [2*NQ_MAX_SIZE-2:0] fall_taken;
    logic [SOL_W-1:0]        sol_cnt;
    logic [TEST_W-1:0]       test_cnt;
    nq_record_t              pending_records [$];
    int                      failures = 0;
    int                      searches = 0;
    int                      records  = 0;
    int                      max_board = 0;

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
      if (idx == REG_BOARD_SIZE) begin
        board_cfg = data[BOARD_W-1:0];
      end else if (idx == REG_SHOWN_SOLS) begin
        show_cfg = data[SHOW_W-1:0];
      end
    endfunction

    function void flip(int col, int row);
      rows_taken[row] = ~rows_taken[row];
      rise_taken[row + col] = ~rise_taken[row + col];
      fall_taken[row + NQ_MAX_SIZE - 1 - col] = ~fall_taken[row + NQ_MAX_SIZE - 1 - col];
    endfunction

    // full backtracking search, placement beats then the summary beat
    function void note_beat(logic start);
      int         n;
      int         col;
      int         row;
      int         shown;
      bit         busy;
      nq_record_t r;
      if (!start) return;
      n = (board_cfg > NQ_MAX_SIZE) ? NQ_MAX_SIZE : int'(board_cfg);
      if (n > max_board) max_board = n;
      searches++;
      foreach (col_rows[i]) col_rows[i] = '0;
      rows_taken = '0;
      rise_taken = '0;
      fall_taken = '0;
      sol_cnt = '0;
      test_cnt = '0;
      col = 0;
      row = 0;
      shown = 0;
      busy = 1'b1;
      while (busy) begin
        if (col >= n || row >= n) begin
          if (col >= n) begin
            if (sol_cnt != SOL_MAX) sol_cnt++;
            if (sol_cnt <= show_cfg && shown < 3) begin
              r.kind = KIND_SOLUTION;
              r.number = sol_cnt[SHOW_W-1:0];
              r.rows = '0;
              for (int c = 0; c < n; c++) r.rows |= ROWS_OUT_W'(col_rows[c]) << (QROW_W * c);
              r.sol_total = '0;
              r.test_total = '0;
              r.last = 1'b0;
              pending_records.push_back(r);
              shown++;
            end
          end
          if (col == 0) begin
            busy = 1'b0;
          end else begin
            col--;
            row = col_rows[col];
            flip(col, row);
            col_rows[col] = '0;
            row++;
          end
        end else begin
          if (test_cnt != TEST_MAX) test_cnt++;
          if (!rows_taken[row] && !rise_taken[row + col] &&
              !fall_taken[row + NQ_MAX_SIZE - 1 - col]) begin
            flip(col, row);
            col_rows[col] = QROW_W'(row);
            col++;
            row = 0;
          end else begin
            row++;
          end
        end
      end
      r.kind = KIND_SUMMARY;
      r.number = '0;
      r.rows = '0;
      r.sol_total = sol_cnt;
      r.test_total = test_cnt;
      r.last = 1'b1;
      pending_records.push_back(r);
    endfunction

    function void check_beat(nq_record_t got);
      nq_record_t want;
      records++;
      if (pending_records.size() == 0) begin
        failures++;
        if (failures <= REPORT_LIMIT)
          $display("beat error: unexpected beat kind %0d num %0d rows %h sols %0d tests %0d last %0d",
                   got.kind, got.number, got.rows, got.sol_total, got.test_total, got.last);
        return;
      end
      want = pending_records.pop_front();
      if (got.kind !== want.kind || got.number !== want.number || got.rows !== want.rows ||
          got.sol_total !== want.sol_total || got.test_total !== want.test_total ||
          got.last !== want.last) begin
        failures++;
        if (failures <= REPORT_LIMIT) begin
          $display("beat error: got  kind %0d num %0d rows %h sols %0d tests %0d last %0d",
                   got.kind, got.number, got.rows, got.sol_total, got.test_total, got.last);
          $display("            want kind %0d num %0d rows %h sols %0d tests %0d last %0d",
                   want.kind, want.number, want.rows, want.sol_total, want.test_total,
                   want.last);
        end
      end
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_W-1:0]      cfg_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic                  in_start_req = 1'b0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic                  out_record_kind;
  logic [SHOW_W-1:0]     out_solution_number;
  logic [ROWS_OUT_W-1:0] out_queen_rows;
  logic [SOL_W-1:0]      out_solution_total;
  logic [TEST_W-1:0]     out_tests_total;
  logic                  out_last;

  bit           quiet = 1'b0;
  nq_scoreboard sb;

  n_queens_solution_counter i_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_wr_en           (cfg_wr_en),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_start_req        (in_start_req),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_record_kind     (out_record_kind),
    .out_solution_number (out_solution_number),
    .out_queen_rows      (out_queen_rows),
    .out_solution_total  (out_solution_total),
    .out_tests_total     (out_tests_total),
    .out_last            (out_last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_stall <= quiet ? 1'b0 : ($urandom_range(99) < 8);
  end

  always @(posedge clk) begin
    nq_record_t got;
    if (rst_n && out_valid && !out_stall) begin
      got.kind = out_record_kind;
      got.number = out_solution_number;
      got.rows = out_queen_rows;
      got.sol_total = out_solution_total;
      got.test_total = out_tests_total;
      got.last = out_last;
      sb.check_beat(got);
    end
  end

  // enable stays high so back-to-back writes need no toggle; cfg_idle drops it
  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    sb.write_reg(idx, data);
  endtask

  task automatic cfg_idle();
    cfg_wr_en <= 1'b0;
  endtask

  task automatic program_board(input int size, input int show);
    cfg_write(REG_BOARD_SIZE, CFG_W'(size));
    cfg_write(REG_SHOWN_SOLS, CFG_W'(($urandom_range(0, 7) << SHOW_W) | show));
    cfg_idle();
  endtask

  task automatic send_beat(input logic start);
    if (!quiet && $urandom_range(99) < 8) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_start_req <= start;
    do @(posedge clk); while (in_stall);
    sb.note_beat(start);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending_records.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic run_starts(input int count);
    repeat (count) send_beat(1'b1);
    drain();
  endtask

  initial begin
    int phase;
    int started;
    int pick;
    int waited;
    sb = new;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings, a no-request beat first
    send_beat(1'b0);
    send_beat(1'b1);
    drain();
    program_board(0, 1);
    run_starts(1);
    program_board(0, 0);
    run_starts(1);
    program_board(1, 3);
    run_starts(2);
    program_board(2, 3);
    run_starts(1);
    program_board(3, 2);
    run_starts(1);
    program_board(4, 3);
    run_starts(1);
    program_board(5, 3);
    run_starts(1);
    program_board(6, 2);
    run_starts(1);
    program_board(6, 0);
    run_starts(1);
    // oversize value overwritten, unknown index must be ignored
    cfg_write(REG_BOARD_SIZE, 5'd31);
    cfg_write(REG_BOARD_SIZE, 5'd5);
    cfg_write(2'd3, 5'h1f);
    cfg_write(2'd2, 5'h00);
    cfg_write(REG_SHOWN_SOLS, 5'd1);
    cfg_idle();
    run_starts(1);
    program_board(7, 3);
    run_starts(1);
    program_board(9, 3);
    run_starts(1);
    program_board(10, 1);
    run_starts(1);

    phase = 0;
    started = 0;
    while (started < RANDOM_STARTS) begin
      quiet = (phase >= 4 && phase < 12);
      if ($urandom_range(99) < 20) cfg_write(REG_BOARD_SIZE, CFG_W'($urandom_range(16, 31)));
      pick = $urandom_range(99);
      if (pick < 70) program_board($urandom_range(0, 6), $urandom_range(0, 3));
      else if (pick < 95) program_board(7, $urandom_range(0, 3));
      else program_board(8, $urandom_range(0, 3));
      repeat ($urandom_range(1, 5)) begin
        if ($urandom_range(99) < 15) begin
          send_beat(1'b0);
        end else begin
          send_beat(1'b1);
          started++;
        end
      end
      drain();
      phase++;
    end
    quiet = 1'b0;

    waited = 0;
    while (sb.pending_records.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (64) @(posedge clk);
    sb.failures += sb.pending_records.size();
    $display("Ran %0d searches on boards up to %0d, checked %0d result beats, %0d errors.",
             sb.searches, sb.max_board, sb.records, sb.failures);
    if (sb.failures == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #80000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

### files.f
hw/rtl/nqsc_pkg.sv
hw/rtl/nqsc_mask_unit.sv
hw/rtl/n_queens_solution_counter.sv
bench/n_queens_solution_counter_tb.sv
